// ===== hdl/sbu_pkg.sv =====
// ----------------------------------------------------------------------------
// sbu_pkg
// Shared types and opcode constants for the subtract-with-borrow unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sbu_pkg;

  localparam int unsigned AccW   = 16;
  localparam int unsigned CycW   = 4;
  localparam int unsigned LenW   = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  // subtract-with-borrow opcodes
  localparam logic [7:0] OpImm     = 8'hE9;
  localparam logic [7:0] OpAbs     = 8'hED;
  localparam logic [7:0] OpLong    = 8'hEF;
  localparam logic [7:0] OpDp      = 8'hE5;
  localparam logic [7:0] OpDpInd   = 8'hF2;
  localparam logic [7:0] OpDpIndL  = 8'hE7;
  localparam logic [7:0] OpAbsX    = 8'hFD;
  localparam logic [7:0] OpLongX   = 8'hFF;
  localparam logic [7:0] OpAbsY    = 8'hF9;
  localparam logic [7:0] OpDpX     = 8'hF5;
  localparam logic [7:0] OpDpXInd  = 8'hE1;
  localparam logic [7:0] OpDpIndY  = 8'hF1;
  localparam logic [7:0] OpDpIndLY = 8'hF7;
  localparam logic [7:0] OpSr      = 8'hE3;
  localparam logic [7:0] OpSrIndY  = 8'hF3;

  // item function select
  localparam logic FuncSbc  = 1'b0;
  localparam logic FuncLoad = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [CycW-1:0] cycles;
    logic [LenW-1:0] len;
    logic            dp_pen;
    logic            pg_pen;
  } sbu_dec_t;

  typedef struct packed {
    logic            func;
    logic [7:0]      opcode;
    logic [AccW-1:0] operand;
    logic            carry_load;
    logic            wide_accumulator;
    logic            decimal_mode;
    logic            dp_low_nonzero;
    logic            page_cross;
  } sbu_item_t;

  typedef struct packed {
    logic [AccW-1:0] acc_out;
    logic            carry_out;
    logic            overflow_out;
    logic            negative_out;
    logic            zero_out;
    logic [LenW-1:0] pc_advance;
    logic [CycW-1:0] cycle_count;
    logic            bad_opcode;
  } sbu_res_t;

endpackage

`default_nettype wire

// ===== hdl/sbu_decode.sv =====
// ----------------------------------------------------------------------------
// sbu_decode
// Opcode decode: base cycles, length and penalty classes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbu_decode import sbu_pkg::*; (
  input  wire logic [7:0] opcode_i,
  input  wire logic       wide_i,
  output sbu_dec_t        dec_o
);

  always_comb begin
    dec_o = '{valid: 1'b1, cycles: '0, len: '0, dp_pen: 1'b0, pg_pen: 1'b0};
    unique case (opcode_i)
      OpImm: begin
        dec_o.cycles = 4'd2; dec_o.len = 3'd2 + {2'b0, wide_i};
      end
      OpAbs:     begin dec_o.cycles = 4'd4; dec_o.len = 3'd3; end
      OpLong:    begin dec_o.cycles = 4'd5; dec_o.len = 3'd4; end
      OpDp:      begin dec_o.cycles = 4'd3; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; end
      OpDpInd:   begin dec_o.cycles = 4'd5; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; end
      OpDpIndL:  begin dec_o.cycles = 4'd6; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; end
      OpAbsX:    begin dec_o.cycles = 4'd4; dec_o.len = 3'd3; dec_o.pg_pen = 1'b1; end
      OpLongX:   begin dec_o.cycles = 4'd5; dec_o.len = 3'd4; end
      OpAbsY:    begin dec_o.cycles = 4'd4; dec_o.len = 3'd3; dec_o.pg_pen = 1'b1; end
      OpDpX:     begin dec_o.cycles = 4'd4; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; end
      OpDpXInd:  begin dec_o.cycles = 4'd6; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; end
      OpDpIndY: begin
        dec_o.cycles = 4'd5; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; dec_o.pg_pen = 1'b1;
      end
      OpDpIndLY: begin dec_o.cycles = 4'd6; dec_o.len = 3'd2; dec_o.dp_pen = 1'b1; end
      OpSr:      begin dec_o.cycles = 4'd4; dec_o.len = 3'd2; end
      OpSrIndY:  begin dec_o.cycles = 4'd7; dec_o.len = 3'd2; end
      default:   dec_o.valid = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sbu_exec.sv =====
// ----------------------------------------------------------------------------
// sbu_exec
// Execute logic: binary or packed-BCD subtract, flags, load, cycle cost.
// ----------------------------------------------------------------------------
`default_nettype none

module sbu_exec import sbu_pkg::*; (
  input  wire logic [AccW-1:0] acc_i,
  input  wire logic            carry_i,
  input  wire logic            ovf_i,
  input  wire logic            dec_penalty_i,
  input  wire sbu_item_t       item_i,
  output logic [AccW-1:0]      acc_o,
  output logic                 carry_o,
  output logic                 ovf_o,
  output sbu_res_t             res_o
);

  localparam int unsigned NDig = AccW / 4;

  sbu_dec_t        dec;
  logic            wide;
  logic [AccW-1:0] mask;
  logic [AccW-1:0] a;
  logic [AccW-1:0] m;
  logic            borrow_in;
  logic [AccW:0]   bin_diff;
  logic [AccW-1:0] bin_res;
  logic [AccW-1:0] bcd_res;
  logic [NDig:0]   bcd_b;
  logic [AccW-1:0] sub_res;
  logic            sub_carry;
  logic            sub_ovf;
  logic            top_a;
  logic            top_m;
  logic            top_r;
  logic [AccW-1:0] acc_new;
  logic [AccW-1:0] acc_view;

  assign wide = item_i.wide_accumulator;

  sbu_decode u_decode (
    .opcode_i (item_i.opcode),
    .wide_i   (wide),
    .dec_o    (dec)
  );

  assign mask      = wide ? {AccW{1'b1}} : {{(AccW/2){1'b0}}, {(AccW/2){1'b1}}};
  assign a         = acc_i & mask;
  assign m         = item_i.operand & mask;
  assign borrow_in = ~carry_i;

  // binary path
  assign bin_diff = {1'b0, a} - {1'b0, m} - {{AccW{1'b0}}, borrow_in};
  assign bin_res  = bin_diff[AccW-1:0] & mask;

  // decimal path, one digit per step with a borrow chain
  assign bcd_b[0] = borrow_in;
  for (genvar g = 0; g < NDig; g++) begin : g_dig
    logic [4:0] dd;
    assign dd = {1'b0, a[4*g +: 4]} - {1'b0, m[4*g +: 4]} - {4'b0, bcd_b[g]};
    assign bcd_b[g+1]      = dd[4];
    assign bcd_res[4*g +: 4] = dd[4] ? (dd[3:0] - 4'd6) : dd[3:0];
  end

  assign top_a = wide ? a[AccW-1] : a[AccW/2-1];
  assign top_m = wide ? m[AccW-1] : m[AccW/2-1];
  assign top_r = wide ? bin_res[AccW-1] : bin_res[AccW/2-1];

  always_comb begin
    if (item_i.decimal_mode) begin
      sub_res   = bcd_res & mask;
      sub_carry = ~(wide ? bcd_b[NDig] : bcd_b[NDig/2]);
      sub_ovf   = ovf_i;
    end else begin
      sub_res   = bin_res;
      sub_carry = ~(wide ? bin_diff[AccW] : bin_diff[AccW/2]);
      sub_ovf   = (top_a ^ top_m) & (top_a ^ top_r);
    end
  end

  always_comb begin
    acc_o            = acc_i;
    carry_o          = carry_i;
    ovf_o            = ovf_i;
    res_o.pc_advance  = '0;
    res_o.cycle_count = '0;
    res_o.bad_opcode  = 1'b0;
    acc_new = wide ? sub_res : {acc_i[AccW-1:AccW/2], sub_res[AccW/2-1:0]};
    if (item_i.func == FuncLoad) begin
      acc_o   = item_i.operand;
      carry_o = item_i.carry_load;
    end else if (!dec.valid) begin
      res_o.bad_opcode = 1'b1;
    end else begin
      acc_o            = acc_new;
      carry_o          = sub_carry;
      ovf_o            = sub_ovf;
      res_o.pc_advance = dec.len;
      res_o.cycle_count = dec.cycles + {3'b0, wide}
                        + {3'b0, item_i.decimal_mode & dec_penalty_i}
                        + {3'b0, dec.dp_pen & item_i.dp_low_nonzero}
                        + {3'b0, dec.pg_pen & item_i.page_cross};
    end
    acc_view           = acc_o & mask;
    res_o.acc_out      = acc_o;
    res_o.carry_out    = carry_o;
    res_o.overflow_out = ovf_o;
    res_o.negative_out = wide ? acc_view[AccW-1] : acc_view[AccW/2-1];
    res_o.zero_out     = (acc_view == '0);
  end

endmodule

`default_nettype wire

// ===== hdl/subtract_with_borrow_unit.sv =====
// ----------------------------------------------------------------------------
// subtract_with_borrow_unit
// Subtract-with-borrow execute unit with load, flags and cycle cost report.
// ----------------------------------------------------------------------------
// Each item goes into an input register, is executed against the accumulator,
// carry and overflow, and lands in a result register, so the result passes
// through both registers after acceptance; one item is taken per clock
// as long as the result side keeps up. The architectural state is updated when
// an item moves into the result register, so consecutive items see each
// other's results with no gap. Write the decimal penalty register only while
// no items are in flight.
`default_nettype none

module subtract_with_borrow_unit import sbu_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i,      // decimal_cycle_penalty
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // opcode, operand, carry_load, wide_accumulator, decimal_mode,
  // dp_low_nonzero, page_cross, zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tuser,    // func
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // acc_out, carry_out, overflow_out, negative_out, zero_out, pc_advance,
  // cycle_count, zero fill
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tuser     // bad_opcode
);

  logic            pen_q;
  logic            in_vld_q;
  sbu_item_t       item_q;
  logic            out_vld_q;
  sbu_res_t        res_q;
  logic [AccW-1:0] acc_q, acc_d;
  logic            carry_q, carry_d;
  logic            ovf_q, ovf_d;
  sbu_res_t        res_d;
  logic            advance;
  logic            accept;
  sbu_item_t       item_in;

  assign cfg_ready_o = 1'b1;

  assign item_in.func             = s_axis_tuser;
  assign item_in.opcode           = s_axis_tdata[7:0];
  assign item_in.operand          = s_axis_tdata[23:8];
  assign item_in.carry_load       = s_axis_tdata[24];
  assign item_in.wide_accumulator = s_axis_tdata[25];
  assign item_in.decimal_mode     = s_axis_tdata[26];
  assign item_in.dp_low_nonzero   = s_axis_tdata[27];
  assign item_in.page_cross       = s_axis_tdata[28];

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sbu_exec u_exec (
    .acc_i         (acc_q),
    .carry_i       (carry_q),
    .ovf_i         (ovf_q),
    .dec_penalty_i (pen_q),
    .item_i        (item_q),
    .acc_o         (acc_d),
    .carry_o       (carry_d),
    .ovf_o         (ovf_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q     <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      carry_q   <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pen_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        acc_q     <= acc_d;
        carry_q   <= carry_d;
        ovf_q     <= ovf_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.bad_opcode;
  assign m_axis_tdata  = {5'b0, res_q.cycle_count, res_q.pc_advance, res_q.zero_out,
                          res_q.negative_out, res_q.overflow_out, res_q.carry_out,
                          res_q.acc_out};

  a_bad_no_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> res_q.pc_advance == '0 && res_q.cycle_count == '0)
    else $error("bad opcode result reports nonzero length or cycles");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("executed item did not reach the result register");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(acc_q) && $stable(carry_q) && $stable(ovf_q))
    else $error("state changed without an item executing");

  a_result_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_q.acc_out == acc_q)
    else $error("result accumulator differs from state");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the subtract-with-borrow unit.
// A queue-fed driver sends instruction items in bursts and a monitor predicts
// accumulator, flags, length and cycle cost for each item it sees accepted.
// Each result is checked field by field, in order, against those predictions.
// The receiver stalls randomly, on a fixed pattern and once for a long stretch.
// ----------------------------------------------------------------------------

module tb;
  import sbu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned LongHold   = 300;

  localparam int RxAlways  = 0;
  localparam int RxRandom  = 1;
  localparam int RxPattern = 2;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = FuncSbc;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  subtract_with_borrow_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  sbu_item_t   instr_q[$];
  sbu_res_t    sbc_outcome_q[$];
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatches   = 0;
  int unsigned load_cnt     = 0;
  int unsigned bad_cnt      = 0;
  int unsigned bcd_cnt      = 0;
  int unsigned wide_cnt     = 0;
  int unsigned cycle_cnt    = 0;

  // architectural state as the unit should hold it
  logic [AccW-1:0] model_acc     = '0;
  logic            model_carry   = 1'b0;
  logic            model_ovf     = 1'b0;
  logic            model_penalty = 1'b0;

  // traffic shaping
  bit          tx_bursty     = 1'b1;
  int          rx_mode       = RxAlways;
  bit          long_hold_req = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_tick       = 0;

  function automatic logic [7:0] sbc_opcode(int k);
    case (k)
      0:       return OpImm;
      1:       return OpAbs;
      2:       return OpLong;
      3:       return OpDp;
      4:       return OpDpInd;
      5:       return OpDpIndL;
      6:       return OpAbsX;
      7:       return OpLongX;
      8:       return OpAbsY;
      9:       return OpDpX;
      10:      return OpDpXInd;
      11:      return OpDpIndY;
      12:      return OpDpIndLY;
      13:      return OpSr;
      default: return OpSrIndY;
    endcase
  endfunction

  function automatic sbu_item_t mk_instr(logic fn, logic [7:0] op, logic [AccW-1:0] val,
                                         logic cl, logic wide, logic dec, logic dp,
                                         logic pg);
    sbu_item_t it;
    it.func             = fn;
    it.opcode           = op;
    it.operand          = val;
    it.carry_load       = cl;
    it.wide_accumulator = wide;
    it.decimal_mode     = dec;
    it.dp_low_nonzero   = dp;
    it.page_cross       = pg;
    return it;
  endfunction

  function automatic sbu_item_t rand_instr();
    logic            fn;
    logic [7:0]      op;
    logic [AccW-1:0] val;
    int              sel;
    fn = ($urandom_range(0, 99) < 12) ? FuncLoad : FuncSbc;
    if ($urandom_range(0, 99) < 88) op = sbc_opcode($urandom_range(0, 14));
    else op = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    case (sel)
      0:       val = 16'h0000;
      1:       val = 16'hFFFF;
      2, 3:    val = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                      4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: val = 16'($urandom_range(0, 65535));
    endcase
    return mk_instr(fn, op, val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 99) < 40, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
  endfunction

  task automatic queue_instr(sbu_item_t it);
    instr_q.push_back(it);
    queued_cnt++;
  endtask

  // computes the result of one item and advances the model state
  function automatic sbu_res_t predict_sbc(sbu_item_t it);
    sbu_res_t        r;
    logic [AccW-1:0] mask, top, a, m, res;
    logic [AccW:0]   diff;
    logic [CycW-1:0] cyc;
    logic [LenW-1:0] len;
    logic            dp, pg, known, brw;
    int              i, ndig, d, da, dm;
    mask  = it.wide_accumulator ? 16'hFFFF : 16'h00FF;
    top   = it.wide_accumulator ? 16'h8000 : 16'h0080;
    cyc   = '0;
    len   = '0;
    dp    = 1'b0;
    pg    = 1'b0;
    known = 1'b1;
    case (it.opcode)
      OpImm:     begin cyc = 4'd2; len = it.wide_accumulator ? 3'd3 : 3'd2; end
      OpAbs:     begin cyc = 4'd4; len = 3'd3; end
      OpLong:    begin cyc = 4'd5; len = 3'd4; end
      OpDp:      begin cyc = 4'd3; len = 3'd2; dp = 1'b1; end
      OpDpInd:   begin cyc = 4'd5; len = 3'd2; dp = 1'b1; end
      OpDpIndL:  begin cyc = 4'd6; len = 3'd2; dp = 1'b1; end
      OpAbsX:    begin cyc = 4'd4; len = 3'd3; pg = 1'b1; end
      OpLongX:   begin cyc = 4'd5; len = 3'd4; end
      OpAbsY:    begin cyc = 4'd4; len = 3'd3; pg = 1'b1; end
      OpDpX:     begin cyc = 4'd4; len = 3'd2; dp = 1'b1; end
      OpDpXInd:  begin cyc = 4'd6; len = 3'd2; dp = 1'b1; end
      OpDpIndY:  begin cyc = 4'd5; len = 3'd2; dp = 1'b1; pg = 1'b1; end
      OpDpIndLY: begin cyc = 4'd6; len = 3'd2; dp = 1'b1; end
      OpSr:      begin cyc = 4'd4; len = 3'd2; end
      OpSrIndY:  begin cyc = 4'd7; len = 3'd2; end
      default:   known = 1'b0;
    endcase
    r = '0;
    if (it.func == FuncLoad) begin
      model_acc   = it.operand;
      model_carry = it.carry_load;
      cyc = '0;
      len = '0;
    end else if (!known) begin
      r.bad_opcode = 1'b1;
    end else begin
      a   = model_acc & mask;
      m   = it.operand & mask;
      brw = !model_carry;
      if (it.decimal_mode) begin
        res  = '0;
        ndig = it.wide_accumulator ? 4 : 2;
        for (i = 0; i < ndig; i++) begin
          da = int'(a[4*i +: 4]);
          dm = int'(m[4*i +: 4]);
          d  = da - dm - int'(brw);
          if (d < 0) begin
            d   = d - 6;
            brw = 1'b1;
          end else begin
            brw = 1'b0;
          end
          res[4*i +: 4] = d[3:0];
        end
        model_carry = !brw;
      end else begin
        diff = {1'b0, a} - {1'b0, m} - {{AccW{1'b0}}, brw};
        res  = diff[AccW-1:0] & mask;
        model_carry = it.wide_accumulator ? !diff[16] : !diff[8];
        model_ovf   = |((a ^ m) & (a ^ res) & top);
      end
      model_acc = it.wide_accumulator ? res : {model_acc[15:8], res[7:0]};
      cyc = cyc + {3'b0, it.wide_accumulator} + {3'b0, it.decimal_mode & model_penalty}
                + {3'b0, dp & it.dp_low_nonzero} + {3'b0, pg & it.page_cross};
    end
    res            = model_acc & mask;
    r.acc_out      = model_acc;
    r.carry_out    = model_carry;
    r.overflow_out = model_ovf;
    r.negative_out = |(res & top);
    r.zero_out     = (res == '0);
    r.pc_advance   = len;
    r.cycle_count  = cyc;
    return r;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endfunction

  // driver: bursts of items, with random gaps when tx_bursty is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= FuncSbc;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (instr_q.size() > 0) begin
        sbu_item_t it;
        it = instr_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {3'b000, it.page_cross, it.dp_low_nonzero, it.decimal_mode,
                          it.wide_accumulator, it.carry_load, it.operand, it.opcode};
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0 && tx_bursty) gap_left = $urandom_range(0, 8);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      logic rdy;
      rx_tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RxAlways: rdy = 1'b1;
          RxRandom: rdy = ($urandom_range(0, 99) < 60);
          default:  rdy = ((rx_tick % 7) < 4);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // monitor: predict on acceptance, check in order on delivery
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) model_penalty = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        sbu_item_t it;
        it.func             = s_axis_tuser;
        it.opcode           = s_axis_tdata[7:0];
        it.operand          = s_axis_tdata[23:8];
        it.carry_load       = s_axis_tdata[24];
        it.wide_accumulator = s_axis_tdata[25];
        it.decimal_mode     = s_axis_tdata[26];
        it.dp_low_nonzero   = s_axis_tdata[27];
        it.page_cross       = s_axis_tdata[28];
        sbc_outcome_q.push_back(predict_sbc(it));
        accepted_cnt++;
        if (it.func == FuncLoad) load_cnt++;
        else if (sbc_outcome_q[$].bad_opcode) bad_cnt++;
        else begin
          if (it.decimal_mode) bcd_cnt++;
          if (it.wide_accumulator) wide_cnt++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (sbc_outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser %0b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          sbu_res_t want;
          want = sbc_outcome_q.pop_front();
          checked_cnt++;
          check_field("acc_out",      32'(want.acc_out),      32'(m_axis_tdata[15:0]));
          check_field("carry_out",    32'(want.carry_out),    32'(m_axis_tdata[16]));
          check_field("overflow_out", 32'(want.overflow_out), 32'(m_axis_tdata[17]));
          check_field("negative_out", 32'(want.negative_out), 32'(m_axis_tdata[18]));
          check_field("zero_out",     32'(want.zero_out),     32'(m_axis_tdata[19]));
          check_field("pc_advance",   32'(want.pc_advance),   32'(m_axis_tdata[22:20]));
          check_field("cycle_count",  32'(want.cycle_count),  32'(m_axis_tdata[26:23]));
          check_field("bad_opcode",   32'(want.bad_opcode),   32'(m_axis_tuser));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d results still outstanding", $time, sbc_outcome_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_cnt != queued_cnt || sbc_outcome_q.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_penalty(logic v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int k;
    int ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: borrow wrap, overflow, kept upper byte, BCD borrow and bad digits
    write_penalty(1'b0);
    queue_instr(mk_instr(FuncLoad, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  OpImm, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncLoad, 8'hFF, 16'hAB80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  OpAbs, 16'hFF01, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    queue_instr(mk_instr(FuncLoad, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  OpImm, 16'h0001, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  OpLong, 16'h0001, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncLoad, 8'h00, 16'h00FA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  OpDp, 16'h000B, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    queue_instr(mk_instr(FuncLoad, 8'h00, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  OpImm, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_instr(mk_instr(FuncSbc,  8'hFE, 16'h1234, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    for (k = 0; k < 15; k++)
      queue_instr(mk_instr(FuncSbc, sbc_opcode(k), 16'($urandom_range(0, 65535)), 1'b0,
                           k[0], k[1], 1'b1, 1'b1));
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      write_penalty(!ph[0]);
      tx_bursty = (ph == 0 || ph == 3);
      rx_mode   = (ph == 0) ? RxRandom : (ph == 3) ? RxPattern : RxAlways;
      if (ph == 2) long_hold_req = 1'b1;
      repeat (500) queue_instr(rand_instr());
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (sbc_outcome_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, sbc_outcome_q.size());
    end
    $display("Covered %0d items: %0d loads, %0d bad opcodes, %0d BCD and %0d 16-bit subtracts.",
             accepted_cnt, load_cnt, bad_cnt, bcd_cnt, wide_cnt);
    $display("Checked %0d results with decimal penalty off and on, %0d mismatches.",
             checked_cnt, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
